// ----- src/lms_pkg.sv -----
// Shared types and command codes for the longest-match substitution block.
package lms_pkg;

   localparam int CP_W = 21;

   typedef enum logic [2:0] {
      CMD_DATA  = 3'd0,
      CMD_HDR   = 3'd1,
      CMD_PAT   = 3'd2,
      CMD_REPL  = 3'd3,
      CMD_DRAIN = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [2:0]      command;
      logic [6:0]      entry_index;
      logic [3:0]      char_pos;
      logic [CP_W-1:0] char_value;
      logic [4:0]      match_length;
      logic [3:0]      repl_length;
      logic            lenient_only;
   } req_type;

   typedef struct packed {
      logic [CP_W-1:0] out_char;
      logic            char_valid;
      logic            window_empty;
      logic            last_of_run;
   } rsp_type;

endpackage

// ----- src/longest_match_substitution_top.sv -----
// Top level of the longest-match dictionary substitution block.
//
//  channel  direction  handshake        word
//  req      in         valid / stall    req_type: command and table data
//  csr      in         valid / ready    lenient_mode bit
//  rsp      out        valid / stall    rsp_type: one emitted codepoint
//
// A table write, a spare command or a data word that leaves the window short is taken
// while the block is idle, and the next word can follow unless a result word is stalled.
// A resolve walks every entry, paced by one pattern-memory read port with a read wait
// before each character compare; each emitted word then takes a replacement read step
// and an emit step. Reset clears the entry headers in a pass over every entry, during
// which no request is taken. A stalled result word holds the emit steps and the input;
// the entry walk runs on.
module longest_match_substitution_top
   import lms_pkg::*;
#(
   parameter int ENTRIES   = 128,
   parameter int MAX_MATCH = 16,
   parameter int MAX_REPL  = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int MW = (MAX_MATCH > 1) ? $clog2(MAX_MATCH) : 1;
   localparam int RW = (MAX_REPL > 1) ? $clog2(MAX_REPL) : 1;
   localparam int CW = $clog2(MAX_MATCH + 1);
   localparam int RCW = $clog2(MAX_REPL + 1);
   localparam int HW = 5 + 4 + 1;
   localparam int PAW = (ENTRIES * MAX_MATCH > 1) ? $clog2(ENTRIES * MAX_MATCH) : 1;
   localparam int RAW = (ENTRIES * MAX_REPL > 1) ? $clog2(ENTRIES * MAX_REPL) : 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HREAD, S_HCHK, S_CMP, S_PWAIT, S_RREAD, S_EMIT, S_STAT
   } state_type;

   // memories
   logic [HW-1:0]   hdr_mem  [ENTRIES];
   logic [CP_W-1:0] pat_mem  [ENTRIES*MAX_MATCH];
   logic [CP_W-1:0] repl_mem [ENTRIES*MAX_REPL];
   logic [CP_W-1:0] win_ff   [MAX_MATCH];

   state_type       state_ff;
   logic            lenient_ff;
   logic [CW-1:0]   count_ff;
   logic [EW:0]     ent_ff;
   logic [MW-1:0]   j_ff;
   logic [CW-1:0]   best_len_ff;
   logic [EW-1:0]   best_ff;
   logic [RCW-1:0]  best_rl_ff;
   logic [RCW-1:0]  rl_ff;
   logic [RW:0]     rk_ff;
   logic [CW-1:0]   ml_ff;
   logic [HW-1:0]   hdr_rd_ff;
   logic [CP_W-1:0] pat_rd_ff;
   logic [CP_W-1:0] repl_rd_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;

   logic [4:0] hml;
   logic [3:0] hrl;
   logic       hlen;
   logic       out_free;
   logic       take;
   logic       rsp_load;
   req_type    rq;
   logic [EW-1:0]  hdr_wr_addr;
   logic [PAW-1:0] pat_wr_addr;
   logic [PAW-1:0] pat_rd_addr;
   logic [RAW-1:0] repl_wr_addr;
   logic [RAW-1:0] repl_rd_addr;

   assign rq        = req_data;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign hml  = hdr_rd_ff[9:5];
   assign hrl  = hdr_rd_ff[4:1];
   assign hlen = hdr_rd_ff[0];

   // memory addresses
   assign hdr_wr_addr  = EW'(rq.entry_index);
   assign pat_wr_addr  = PAW'(32'(rq.entry_index) * MAX_MATCH + 32'(rq.char_pos));
   assign pat_rd_addr  = PAW'(32'(ent_ff[EW-1:0]) * MAX_MATCH + 32'(j_ff));
   assign repl_wr_addr = RAW'(32'(rq.entry_index) * MAX_REPL + 32'(rq.char_pos));
   assign repl_rd_addr = RAW'(32'(best_ff) * MAX_REPL + 32'(rk_ff[RW-1:0]));

   // load a new result word this cycle
   assign rsp_load = (take && rq.command == CMD_DRAIN && count_ff == '0)
                     || (state_ff == S_EMIT && out_free)
                     || (state_ff == S_STAT && out_free
                         && (best_len_ff == '0 || best_rl_ff == '0));

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         lenient_ff <= 1'b0;
      end else if (csr_valid) begin
         lenient_ff <= csr_data;
      end
   end

   // result valid: set on load, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // header memory: clearing pass, table writes and walk reads
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         hdr_mem[ent_ff[EW-1:0]] <= '0;
      end else if (take && rq.command == CMD_HDR && 32'(rq.entry_index) < ENTRIES) begin
         hdr_mem[hdr_wr_addr] <= {rq.match_length, rq.repl_length, rq.lenient_only};
      end
      hdr_rd_ff <= hdr_mem[ent_ff[EW-1:0]];
   end

   // pattern memory
   always_ff @(posedge clock) begin
      if (take && rq.command == CMD_PAT && 32'(rq.entry_index) < ENTRIES
          && 32'(rq.char_pos) < MAX_MATCH) begin
         pat_mem[pat_wr_addr] <= rq.char_value;
      end
      pat_rd_ff <= pat_mem[pat_rd_addr];
   end

   // replacement memory
   always_ff @(posedge clock) begin
      if (take && rq.command == CMD_REPL && 32'(rq.entry_index) < ENTRIES
          && 32'(rq.char_pos) < MAX_REPL) begin
         repl_mem[repl_wr_addr] <= rq.char_value;
      end
      repl_rd_ff <= repl_mem[repl_rd_addr];
   end

   // sequencer: window, walk, emit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ent_ff       <= '0;
         count_ff     <= '0;
         j_ff         <= '0;
         rk_ff        <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               if (32'(ent_ff) == ENTRIES - 1) begin
                  ent_ff   <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  ent_ff <= ent_ff + 1'b1;
               end
            end
            S_IDLE: begin
               ent_ff      <= '0;
               j_ff        <= '0;
               best_len_ff <= '0;
               if (take) begin
                  if (rq.command == CMD_DATA) begin
                     if (32'(count_ff) < MAX_MATCH) begin
                        win_ff[count_ff[MW-1:0]] <= rq.char_value;
                        if (32'(count_ff) == MAX_MATCH - 1) state_ff <= S_HREAD;
                        count_ff <= count_ff + 1'b1;
                     end else begin
                        state_ff <= S_HREAD;
                     end
                  end else if (rq.command == CMD_DRAIN) begin
                     if (count_ff == '0) begin
                        rsp_ff       <= '{out_char: '0, char_valid: 1'b0,
                                          window_empty: 1'b1, last_of_run: 1'b1};
                     end else begin
                        state_ff <= S_HREAD;
                     end
                  end
               end
            end
            S_HREAD: begin
               // header read in flight
               if (32'(ent_ff) >= ENTRIES) begin
                  state_ff <= S_RREAD;
                  rk_ff    <= '0;
               end else begin
                  state_ff <= S_HCHK;
               end
            end
            S_HCHK: begin
               if (hml == 5'd0 || 32'(hml) > MAX_MATCH || 32'(hml) > 32'(count_ff)
                   || 32'(hml) <= 32'(best_len_ff) || (hlen && !lenient_ff)) begin
                  ent_ff   <= ent_ff + 1'b1;
                  state_ff <= S_HREAD;
               end else begin
                  ml_ff    <= CW'(hml);
                  rl_ff    <= (32'(hrl) > MAX_REPL) ? RCW'(MAX_REPL) : RCW'(hrl);
                  state_ff <= S_PWAIT;
               end
            end
            S_PWAIT: begin
               // pattern char j in flight
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (pat_rd_ff != win_ff[j_ff]) begin
                  j_ff     <= '0;
                  ent_ff   <= ent_ff + 1'b1;
                  state_ff <= S_HREAD;
               end else if (32'(j_ff) + 1 == 32'(ml_ff)) begin
                  best_len_ff <= ml_ff;
                  best_ff     <= ent_ff[EW-1:0];
                  best_rl_ff  <= rl_ff;
                  j_ff        <= '0;
                  ent_ff      <= ent_ff + 1'b1;
                  state_ff    <= S_HREAD;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= S_PWAIT;
               end
            end
            S_RREAD: begin
               // replacement char rk in flight
               if (best_len_ff == '0) begin
                  state_ff <= S_STAT;
               end else if (32'(rk_ff) == 32'(best_rl_ff)) begin
                  state_ff <= S_STAT;
               end else begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_ff.out_char   <= repl_rd_ff;
                  rsp_ff.char_valid <= 1'b1;
                  rsp_ff.window_empty <= (count_ff == best_len_ff);
                  rsp_ff.last_of_run  <= (32'(rk_ff) + 1 == 32'(best_rl_ff));
                  rk_ff    <= rk_ff + 1'b1;
                  state_ff <= (32'(rk_ff) + 1 == 32'(best_rl_ff)) ? S_STAT : S_RREAD;
               end
            end
            S_STAT: begin
               if (out_free || (best_len_ff != '0 && best_rl_ff != '0)) begin
                  if (best_len_ff == '0) begin
                     rsp_ff <= '{out_char: win_ff[0], char_valid: 1'b1,
                                 window_empty: (count_ff == CW'(1)), last_of_run: 1'b1};
                  end else if (best_rl_ff == '0) begin
                     rsp_ff <= '{out_char: '0, char_valid: 1'b0,
                                 window_empty: (count_ff == best_len_ff), last_of_run: 1'b1};
                  end
                  for (int i = 0; i < MAX_MATCH; i++) begin
                     if (best_len_ff == '0) begin
                        if (i + 1 < MAX_MATCH) win_ff[i] <= win_ff[i + 1];
                     end else if (i + 32'(best_len_ff) < MAX_MATCH) begin
                        win_ff[i] <= win_ff[i + 32'(best_len_ff)];
                     end
                  end
                  count_ff <= count_ff - ((best_len_ff == '0) ? CW'(1) : best_len_ff);
                  ent_ff   <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
